// ===== src/brc_pkg.sv =====
// Shared types, constants and width helpers for the box region IoU classifier.
// No dependencies; the lane, cell, divider, top and testbench refer to it by scoped names.
package brc_pkg;

   // Image size registers.
   localparam int REG_BITS      = 12;
   localparam int RESET_WIDTH   = 640;
   localparam int RESET_HEIGHT  = 480;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes, taken from the word address of a write.
   localparam logic REG_IDX_WIDTH  = 1'b0;
   localparam logic REG_IDX_HEIGHT = 1'b1;

   // Region codes.
   localparam int REGION_COUNT = 5;
   typedef logic [2:0] region_type;
   localparam region_type REGION_LT     = 3'd0;
   localparam region_type REGION_RT     = 3'd1;
   localparam region_type REGION_LB     = 3'd2;
   localparam region_type REGION_RB     = 3'd3;
   localparam region_type REGION_CENTRE = 3'd4;

   // A region side in quarter pixels never exceeds twice the image size plus one
   // pixel, so the overlap extent and the region extent fit in this width.
   localparam int EXTENT_BITS = REG_BITS + 2;
   localparam int INTER_BITS  = 2 * EXTENT_BITS;

   // Width of a quarter-pixel coordinate that holds both box and region corners.
   function automatic int quarter_bits(int coord_bits);
      int box_q;
      int reg_q;
      box_q = coord_bits + 2;
      reg_q = REG_BITS + 2;
      return (box_q > reg_q) ? box_q : reg_q;
   endfunction

   // Width of the union area in sixteenths of a square pixel.
   function automatic int den_bits(int coord_bits);
      int box_area;
      box_area = 2 * (coord_bits + 3);
      return ((box_area > INTER_BITS) ? box_area : INTER_BITS) + 1;
   endfunction

endpackage

// ===== src/brc_req_if.sv =====
// Request channel of the box region IoU classifier: one detection box per request.
// Depends on nothing.
interface brc_req_if #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] box_left;
   logic [COORD_BITS-1:0] box_top;
   logic [COORD_BITS-1:0] box_right;
   logic [COORD_BITS-1:0] box_bottom;

   modport source(output valid, box_left, box_top, box_right, box_bottom, input ready);
   modport sink(input valid, box_left, box_top, box_right, box_bottom, output ready);
endinterface

// ===== src/brc_rsp_if.sv =====
// Result channel of the box region IoU classifier: chosen region and its IoU.
// Depends on nothing.
interface brc_rsp_if #(
   parameter int OVERLAP_FRAC_BITS = 16
);
   logic                       valid;
   logic                       ready;
   logic [2:0]                 region;
   logic [OVERLAP_FRAC_BITS:0] best_overlap;

   modport source(output valid, region, best_overlap, input ready);
   modport sink(input valid, region, best_overlap, output ready);
endinterface

// ===== src/brc_lane.sv =====
// One region lane: intersection and union areas of a box against one fixed region.
// Three register stages; depends on brc_pkg.
module brc_lane #(
   parameter int                  COORD_BITS = 12,
   parameter brc_pkg::region_type REGION     = brc_pkg::REGION_LT
) (
   input  logic                                      clock,
   input  logic                                      en,
   input  logic [COORD_BITS-1:0]                     box_left,
   input  logic [COORD_BITS-1:0]                     box_top,
   input  logic [COORD_BITS-1:0]                     box_right,
   input  logic [COORD_BITS-1:0]                     box_bottom,
   input  logic [brc_pkg::REG_BITS-1:0]              image_width,
   input  logic [brc_pkg::REG_BITS-1:0]              image_height,
   output logic [brc_pkg::INTER_BITS-1:0]            num,
   output logic [brc_pkg::den_bits(COORD_BITS)-1:0]  den
);
   localparam int XW  = brc_pkg::quarter_bits(COORD_BITS);
   localparam int EW  = brc_pkg::EXTENT_BITS;
   localparam int NW  = brc_pkg::INTER_BITS;
   localparam int BW  = COORD_BITS + 3;
   localparam int DW  = brc_pkg::den_bits(COORD_BITS);

   logic [XW-1:0] w1, w2, w3, w4, h1, h2, h3, h4;
   logic [XW-1:0] rl, rt, rr, rb;
   logic [XW-1:0] bl, bt, br, bb;
   logic [XW-1:0] x1, y1, x2, y2;
   logic [XW-1:0] dx_full, dy_full, rw_full, rh_full;
   logic          empty;

   logic          empty1_in, empty1_ff;
   logic [EW-1:0] dx_in, dx_ff, dy_in, dy_ff, rw_in, rw_ff, rh_in, rh_ff;
   logic [BW-1:0] bw_in, bw_ff, bh_in, bh_ff;

   logic            empty2_ff;
   logic [NW-1:0]   inter_in, inter_ff, ar_in, ar_ff;
   logic [2*BW-1:0] ab_in, ab_ff;

   logic [DW-1:0] uni;
   logic [NW-1:0] num_in, num_ff;
   logic [DW-1:0] den_in, den_ff;

   // Region corners in quarter pixels.
   always_comb begin
      w1 = XW'(image_width);
      w2 = XW'({image_width, 1'b0});
      w4 = XW'({image_width, 2'b00});
      w3 = w1 + w2;
      h1 = XW'(image_height);
      h2 = XW'({image_height, 1'b0});
      h4 = XW'({image_height, 2'b00});
      h3 = h1 + h2;
      unique case (REGION)
         brc_pkg::REGION_RT: begin
            rl = w2; rt = '0; rr = w4; rb = h2;
         end
         brc_pkg::REGION_LB: begin
            rl = '0; rt = h2; rr = w2; rb = h4;
         end
         brc_pkg::REGION_RB: begin
            rl = w2; rt = h2; rr = w4; rb = h4;
         end
         brc_pkg::REGION_CENTRE: begin
            rl = w1; rt = h1; rr = w3; rb = h3;
         end
         default: begin
            rl = '0; rt = '0; rr = w2; rb = h2;
         end
      endcase
   end

   // Stage 1: overlap rectangle and side lengths.
   always_comb begin
      bl = XW'({box_left, 2'b00});
      bt = XW'({box_top, 2'b00});
      br = XW'({box_right, 2'b00});
      bb = XW'({box_bottom, 2'b00});
      x1 = (bl > rl) ? bl : rl;
      y1 = (bt > rt) ? bt : rt;
      x2 = (br < rr) ? br : rr;
      y2 = (bb < rb) ? bb : rb;
      empty = (x2 < x1) || (y2 < y1);
      dx_full = x2 - x1 + XW'(4);
      dy_full = y2 - y1 + XW'(4);
      rw_full = rr - rl + XW'(4);
      rh_full = rb - rt + XW'(4);
      empty1_in = empty;
      dx_in = empty ? '0 : dx_full[EW-1:0];
      dy_in = empty ? '0 : dy_full[EW-1:0];
      rw_in = rw_full[EW-1:0];
      rh_in = rh_full[EW-1:0];
      bw_in = BW'({box_right, 2'b00}) - BW'({box_left, 2'b00}) + BW'(4);
      bh_in = BW'({box_bottom, 2'b00}) - BW'({box_top, 2'b00}) + BW'(4);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         empty1_ff <= empty1_in;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         rw_ff     <= rw_in;
         rh_ff     <= rh_in;
         bw_ff     <= bw_in;
         bh_ff     <= bh_in;
      end
   end

   // Stage 2: the three areas.
   always_comb begin
      inter_in = dx_ff * dy_ff;
      ar_in    = rw_ff * rh_ff;
      ab_in    = bw_ff * bh_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         empty2_ff <= empty1_ff;
         inter_ff  <= inter_in;
         ar_ff     <= ar_in;
         ab_ff     <= ab_in;
      end
   end

   // Stage 3: union; an empty overlap reads as 0/1.
   always_comb begin
      uni    = DW'(ab_ff) + DW'(ar_ff) - DW'(inter_ff);
      num_in = empty2_ff ? '0 : inter_ff;
      den_in = empty2_ff ? DW'(1) : uni;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   assign num = num_ff;
   assign den = den_ff;
endmodule

// ===== src/brc_cell.sv =====
// Compare cell: keeps the better of the incoming best and its own region's IoU.
// Two register stages, split cross products then compare; depends on brc_pkg.
module brc_cell #(
   parameter int                  COORD_BITS = 12,
   parameter brc_pkg::region_type REGION     = brc_pkg::REGION_LT
) (
   input  logic                                     clock,
   input  logic                                     en,
   input  logic [brc_pkg::INTER_BITS-1:0]           cand_num,
   input  logic [brc_pkg::den_bits(COORD_BITS)-1:0] cand_den,
   input  logic [brc_pkg::INTER_BITS-1:0]           in_num,
   input  logic [brc_pkg::den_bits(COORD_BITS)-1:0] in_den,
   input  brc_pkg::region_type                      in_idx,
   output logic [brc_pkg::INTER_BITS-1:0]           out_num,
   output logic [brc_pkg::den_bits(COORD_BITS)-1:0] out_den,
   output brc_pkg::region_type                      out_idx
);
   localparam int NW = brc_pkg::INTER_BITS;
   localparam int DW = brc_pkg::den_bits(COORD_BITS);
   localparam int LO = DW / 2;
   localparam int HI = DW - LO;
   localparam int PW = NW + DW;

   logic [NW+LO-1:0] pa_lo_in, pa_lo_ff, pb_lo_in, pb_lo_ff;
   logic [NW+HI-1:0] pa_hi_in, pa_hi_ff, pb_hi_in, pb_hi_ff;
   logic [NW-1:0]    cn_ff, bn_ff;
   logic [DW-1:0]    cd_ff, bd_ff;
   brc_pkg::region_type bi_ff;

   logic [PW-1:0] lhs, rhs;
   logic          take;
   logic [NW-1:0] out_num_in, out_num_ff;
   logic [DW-1:0] out_den_in, out_den_ff;
   brc_pkg::region_type out_idx_in, out_idx_ff;

   // Stage A: candidate * best_den against best_num * candidate_den, each in two halves.
   always_comb begin
      pa_lo_in = cand_num * in_den[LO-1:0];
      pa_hi_in = cand_num * in_den[DW-1:LO];
      pb_lo_in = in_num * cand_den[LO-1:0];
      pb_hi_in = in_num * cand_den[DW-1:LO];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_lo_ff <= pa_lo_in;
         pa_hi_ff <= pa_hi_in;
         pb_lo_ff <= pb_lo_in;
         pb_hi_ff <= pb_hi_in;
         cn_ff    <= cand_num;
         cd_ff    <= cand_den;
         bn_ff    <= in_num;
         bd_ff    <= in_den;
         bi_ff    <= in_idx;
      end
   end

   // Stage B: strictly greater wins, so ties keep the earlier region.
   always_comb begin
      lhs  = PW'(pa_lo_ff) + {pa_hi_ff, {LO{1'b0}}};
      rhs  = PW'(pb_lo_ff) + {pb_hi_ff, {LO{1'b0}}};
      take = lhs > rhs;
      out_num_in = take ? cn_ff : bn_ff;
      out_den_in = take ? cd_ff : bd_ff;
      out_idx_in = take ? REGION : bi_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_num_ff <= out_num_in;
         out_den_ff <= out_den_in;
         out_idx_ff <= out_idx_in;
      end
   end

   assign out_num = out_num_ff;
   assign out_den = out_den_ff;
   assign out_idx = out_idx_ff;
endmodule

// ===== src/brc_div.sv =====
// Pipelined restoring divider: (num << OVERLAP_FRAC_BITS) / den, one quotient bit
// per stage, num never above den. Depends on brc_pkg.
module brc_div #(
   parameter int COORD_BITS        = 12,
   parameter int OVERLAP_FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     en,
   input  logic [brc_pkg::INTER_BITS-1:0]           num,
   input  logic [brc_pkg::den_bits(COORD_BITS)-1:0] den,
   input  brc_pkg::region_type                      idx,
   output logic [OVERLAP_FRAC_BITS:0]               quotient,
   output brc_pkg::region_type                      quotient_idx
);
   localparam int DW = brc_pkg::den_bits(COORD_BITS);
   localparam int S  = OVERLAP_FRAC_BITS + 1;

   logic [DW-1:0] rem_ff [S-1];
   logic [DW-1:0] den_ff [S-1];
   logic [S-1:0]  quo_ff [S];
   brc_pkg::region_type idx_ff [S];

   logic [DW:0]   r0, d0, r0_sub;
   logic          ge0;

   // First stage gives the integer bit, set only when num equals den.
   always_comb begin
      r0     = (DW+1)'(num);
      d0     = {1'b0, den};
      ge0    = r0 >= d0;
      r0_sub = ge0 ? (r0 - d0) : r0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= r0_sub[DW-1:0];
         den_ff[0] <= den;
         quo_ff[0] <= {{(S-1){1'b0}}, ge0};
         idx_ff[0] <= idx;
      end
   end

   for (genvar i = 1; i < S; i++) begin : g_step
      logic [DW:0] rs;
      logic [DW:0] dd;
      logic        ge;

      always_comb begin
         rs = {rem_ff[i-1], 1'b0};
         dd = {1'b0, den_ff[i-1]};
         ge = rs >= dd;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[i] <= {quo_ff[i-1][S-2:0], ge};
            idx_ff[i] <= idx_ff[i-1];
         end
      end

      // The last stage only needs its quotient bit, so only earlier stages keep a remainder.
      if (i < S - 1) begin : g_rem
         logic [DW:0] rn;

         always_comb begin
            rn = ge ? (rs - dd) : rs;
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= rn[DW-1:0];
               den_ff[i] <= den_ff[i-1];
            end
         end
      end
   end

   assign quotient     = quo_ff[S-1];
   assign quotient_idx = idx_ff[S-1];
endmodule

// ===== src/box_region_iou_classifier.sv =====
// Box region IoU classifier. An accepted request passes through 3 lane stages, 2 per
// compare cell over 5 cells, and one per quotient bit in the divider; the last divider
// stage is the output register. Throughput is one request per cycle while the receiver
// takes results, set by the fully pipelined lanes, cells and divider. Reset clears the
// valid pipeline and loads 640 by 480 as image size.
module box_region_iou_classifier #(
   parameter int COORD_BITS        = 12,
   parameter int OVERLAP_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   brc_req_if.sink                             req_chan,
   brc_rsp_if.source                           rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [brc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [brc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [brc_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   localparam int NW  = brc_pkg::INTER_BITS;
   localparam int DW  = brc_pkg::den_bits(COORD_BITS);
   localparam int RB  = brc_pkg::REG_BITS;
   localparam int NR  = brc_pkg::REGION_COUNT;
   localparam int LAT = 3 + 2 * NR + OVERLAP_FRAC_BITS + 1;

   // Configuration registers. A write lands on the access cycle; the word address picks
   // the register, so byte address 0 is the width and 4 the height.
   logic [RB-1:0] width_ff, width_in, height_ff, height_in;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == brc_pkg::REG_IDX_HEIGHT) begin
            height_in = csr_pwdata[RB-1:0];
         end else begin
            width_in = csr_pwdata[RB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RB'(brc_pkg::RESET_WIDTH);
         height_ff <= RB'(brc_pkg::RESET_HEIGHT);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == brc_pkg::REG_IDX_HEIGHT) ?
                       brc_pkg::CSR_DATA_BITS'(height_ff) : brc_pkg::CSR_DATA_BITS'(width_ff);

   // The whole pipeline advances together. It moves whenever the output register is empty
   // or its result is being taken, so a new request enters in the same cycle that a
   // finished result leaves.
   logic           en;
   logic [LAT-1:0] vld_ff, vld_in;

   assign en             = !vld_ff[LAT-1] || rsp_chan.ready;
   assign req_chan.ready = en;

   always_comb begin
      vld_in = vld_ff;
      if (en) begin
         vld_in = {vld_ff[LAT-2:0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Five lanes compute each region's IoU as a numerator and denominator in parallel.
   logic [NW-1:0] lane_num [NR];
   logic [DW-1:0] lane_den [NR];
   logic [NW-1:0] cand_num [NR];
   logic [DW-1:0] cand_den [NR];

   // The compare chain: entry k is the best found over regions below k.
   logic [NW-1:0]       chain_num [NR+1];
   logic [DW-1:0]       chain_den [NR+1];
   brc_pkg::region_type chain_idx [NR+1];

   // The best starts as 0/1 at region 0, so a box that overlaps no region ends there.
   assign chain_num[0] = '0;
   assign chain_den[0] = DW'(1);
   assign chain_idx[0] = brc_pkg::REGION_LT;

   for (genvar k = 0; k < NR; k++) begin : g_region
      brc_lane #(
         .COORD_BITS(COORD_BITS),
         .REGION    (brc_pkg::region_type'(k))
      ) u_lane (
         .clock       (clock),
         .en          (en),
         .box_left    (req_chan.box_left),
         .box_top     (req_chan.box_top),
         .box_right   (req_chan.box_right),
         .box_bottom  (req_chan.box_bottom),
         .image_width (width_ff),
         .image_height(height_ff),
         .num         (lane_num[k]),
         .den         (lane_den[k])
      );

      // Region k meets the chain behind the compare cells of the lower regions, so its lane
      // result waits in a shift line as deep as the compare cells before it.
      if (k == 0) begin : g_direct
         assign cand_num[k] = lane_num[k];
         assign cand_den[k] = lane_den[k];
      end else begin : g_delay
         logic [NW-1:0] dn_ff [2*k];
         logic [DW-1:0] dd_ff [2*k];

         always_ff @(posedge clock) begin
            if (en) begin
               dn_ff[0] <= lane_num[k];
               dd_ff[0] <= lane_den[k];
               for (int j = 1; j < 2 * k; j++) begin
                  dn_ff[j] <= dn_ff[j-1];
                  dd_ff[j] <= dd_ff[j-1];
               end
            end
         end

         assign cand_num[k] = dn_ff[2*k-1];
         assign cand_den[k] = dd_ff[2*k-1];
      end

      brc_cell #(
         .COORD_BITS(COORD_BITS),
         .REGION    (brc_pkg::region_type'(k))
      ) u_cell (
         .clock   (clock),
         .en      (en),
         .cand_num(cand_num[k]),
         .cand_den(cand_den[k]),
         .in_num  (chain_num[k]),
         .in_den  (chain_den[k]),
         .in_idx  (chain_idx[k]),
         .out_num (chain_num[k+1]),
         .out_den (chain_den[k+1]),
         .out_idx (chain_idx[k+1])
      );
   end

   // The winning fraction is turned into a truncated Q1.OVERLAP_FRAC_BITS value.
   logic [OVERLAP_FRAC_BITS:0] quo;
   brc_pkg::region_type        quo_idx;

   brc_div #(
      .COORD_BITS       (COORD_BITS),
      .OVERLAP_FRAC_BITS(OVERLAP_FRAC_BITS)
   ) u_div (
      .clock       (clock),
      .en          (en),
      .num         (chain_num[NR]),
      .den         (chain_den[NR]),
      .idx         (chain_idx[NR]),
      .quotient    (quo),
      .quotient_idx(quo_idx)
   );

   assign rsp_chan.valid        = vld_ff[LAT-1];
   assign rsp_chan.region       = quo_idx;
   assign rsp_chan.best_overlap = quo;

   // An accepted request always shows up at the head of the valid pipeline.
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> vld_ff[0])
      else $error("accepted request missing from the pipeline");

   // The reported IoU never exceeds one.
   a_overlap_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.best_overlap <= (OVERLAP_FRAC_BITS+1)'(1 << OVERLAP_FRAC_BITS)))
      else $error("IoU above one");

   // A width write takes effect on the next cycle.
   a_width_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[2] == brc_pkg::REG_IDX_WIDTH) |=> width_ff == $past(csr_pwdata[RB-1:0]))
      else $error("width register not written");
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the box region IoU classifier.
// Depends on brc_pkg, the brc_req_if and brc_rsp_if interfaces and the top module of the block.
module testbench;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int LATENCY    = FRAC_BITS + 14;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [brc_pkg::CSR_ADDR_BITS-1:0] ADDR_WIDTH  = 3'd0;
   localparam logic [brc_pkg::CSR_ADDR_BITS-1:0] ADDR_HEIGHT = 3'd4;

   typedef struct packed {
      logic [2:0]       region;
      logic [FRAC_BITS:0] overlap;
   } verdict_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [brc_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [brc_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [brc_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   brc_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   brc_rsp_if #(.OVERLAP_FRAC_BITS(FRAC_BITS)) rsp_chan ();

   box_region_iou_classifier #(.COORD_BITS(COORD_BITS), .OVERLAP_FRAC_BITS(FRAC_BITS)) dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // The predictor keeps its own copy of the image size registers.
   logic [brc_pkg::REG_BITS-1:0] img_w, img_h;
   verdict_type expected_verdicts[$];
   int  mismatch_count = 0;
   longint cycle_count = 0;
   logic stall_busy = 1'b0;   // receiver stall pattern on or off

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // A generous cycle limit ends a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // Intersection over union of the box against one region, all in quarter pixels,
   // returned as a numerator and denominator in sixteenths of a square pixel.
   function automatic void region_iou(input longint b[4], input longint r[4],
                                      output longint num, output longint den);
      longint x1, y1, x2, y2, inter, a_box, a_reg, uni;
      x1 = b[0] > r[0] ? b[0] : r[0];
      y1 = b[1] > r[1] ? b[1] : r[1];
      x2 = b[2] < r[2] ? b[2] : r[2];
      y2 = b[3] < r[3] ? b[3] : r[3];
      num = 0;
      den = 1;
      if (x2 < x1 || y2 < y1) return;
      inter = (x2 - x1 + 4) * (y2 - y1 + 4);
      a_box = (b[2] - b[0] + 4) * (b[3] - b[1] + 4);
      a_reg = (r[2] - r[0] + 4) * (r[3] - r[1] + 4);
      uni = a_box + a_reg - inter;
      if (uni <= 0) return;
      num = inter;
      den = uni;
   endfunction

   // Picks the first region with the strictly greatest IoU. Products stay below 2^62,
   // so the cross-multiplied compare is exact in 64 bits.
   function automatic verdict_type classify_box(input logic [11:0] l, input logic [11:0] t,
                                                input logic [11:0] r, input logic [11:0] btm);
      longint b[4], reg_c[4], w, h, num, den, best_num, best_den;
      logic [127:0] q;
      verdict_type v;
      w = img_w;
      h = img_h;
      b[0] = 4 * l; b[1] = 4 * t; b[2] = 4 * r; b[3] = 4 * btm;
      best_num = 0;
      best_den = 1;
      v.region = brc_pkg::REGION_LT;
      for (int k = 0; k < brc_pkg::REGION_COUNT; k++) begin
         case (k)
            0: reg_c = '{0, 0, 2 * w, 2 * h};
            1: reg_c = '{2 * w, 0, 4 * w, 2 * h};
            2: reg_c = '{0, 2 * h, 2 * w, 4 * h};
            3: reg_c = '{2 * w, 2 * h, 4 * w, 4 * h};
            default: reg_c = '{w, h, 3 * w, 3 * h};
         endcase
         region_iou(b, reg_c, num, den);
         if (num * best_den > best_num * den) begin
            best_num = num;
            best_den = den;
            v.region = 3'(k);
         end
      end
      q = (128'(best_num) << FRAC_BITS) / 128'(best_den);
      v.overlap = q[FRAC_BITS:0];
      return v;
   endfunction

   // Sends one box and records its expected verdict once the request is accepted.
   task automatic send_box(input logic [11:0] l, input logic [11:0] t,
                           input logic [11:0] r, input logic [11:0] btm);
      req_chan.valid      <= 1'b1;
      req_chan.box_left   <= l;
      req_chan.box_top    <= t;
      req_chan.box_right  <= r;
      req_chan.box_bottom <= btm;
      do @(posedge clock); while (!req_chan.ready);
      expected_verdicts.push_back(classify_box(l, t, r, btm));
   endtask

   // Random gap between bursts; the valid drops only when a gap is taken.
   int burst_left;
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // One APB write: a setup phase, then the access phase, then idle before the next transfer.
   task automatic write_reg(input logic [brc_pkg::CSR_ADDR_BITS-1:0] addr,
                            input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_WIDTH) img_w = data[brc_pkg::REG_BITS-1:0];
      else img_h = data[brc_pkg::REG_BITS-1:0];
      @(posedge clock);
   endtask

   task automatic set_image(input logic [11:0] w, input logic [11:0] h);
      write_reg(ADDR_WIDTH, {20'hABCDE, w});
      write_reg(ADDR_HEIGHT, {20'h13579, h});
   endtask

   // Checker: every accepted result is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch("unexpected result region", rsp_chan.region, -1);
         end else begin
            verdict_type want;
            want = expected_verdicts.pop_front();
            if (rsp_chan.region !== want.region)
               report_mismatch("region", rsp_chan.region, want.region);
            if (rsp_chan.best_overlap !== want.overlap)
               report_mismatch("best_overlap", rsp_chan.best_overlap, want.overlap);
         end
      end
   end

   // Receiver stalls come in stretches: some with none, others with frequent stalls.
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_busy <= ~stall_busy;
      rsp_chan.ready <= stall_busy ? ($urandom_range(0, 2) != 0) : 1'b1;
   end

   // Extremes of the fields, inverted boxes, exact region hits and ties.
   task automatic test_directed();
      set_image(640, 480);
      send_box(0, 0, 0, 0);
      send_box(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      send_box(0, 0, 12'hFFF, 12'hFFF);
      send_box(0, 0, 320, 240);
      send_box(320, 0, 640, 240);
      send_box(0, 240, 320, 480);
      send_box(320, 240, 640, 480);
      send_box(160, 120, 480, 360);
      send_box(300, 200, 100, 400);   // right below left
      send_box(100, 400, 300, 200);   // bottom below top
      send_box(319, 239, 321, 241);   // equal overlaps with the four quarters, but the centre wins
      send_box(12'hAAA, 12'h555, 12'hAAA, 12'h555);
      send_box(12'h555, 12'hAAA, 12'hFFF, 12'hFFF);
      drain();
      // Zero image size collapses every region to one pixel.
      set_image(0, 0);
      send_box(0, 0, 0, 0);
      send_box(0, 0, 5, 5);
      send_box(1, 1, 3, 3);
      drain();
      set_image(4095, 4095);
      send_box(0, 0, 4095, 4095);
      send_box(1023, 1023, 3071, 3071);
      send_box(2047, 2047, 4095, 4095);
      drain();
      set_image(1, 1);
      send_box(0, 0, 0, 0);
      send_box(1, 1, 1, 1);
      send_box(0, 0, 1, 1);
      drain();
   endtask

   // Random boxes, mostly well formed and starting inside the image, some anywhere.
   task automatic test_random(input int count);
      logic [11:0] a, b, c, d;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            a = $urandom; b = $urandom; c = $urandom; d = $urandom;
         end else begin
            a = $urandom_range(0, img_w);
            b = $urandom_range(0, img_h);
            c = a + $urandom_range(0, img_w);
            d = b + $urandom_range(0, img_h);
         end
         send_box(a, b, c, d);
         pace_sender();
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      burst_left = 0;
      img_w = brc_pkg::RESET_WIDTH;
      img_h = brc_pkg::RESET_HEIGHT;
      req_chan.valid = 1'b0;
      req_chan.box_left = '0;
      req_chan.box_top = '0;
      req_chan.box_right = '0;
      req_chan.box_bottom = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Reset image size first, with no register write.
      test_random(150);
      test_directed();
      set_image(640, 480);
      test_random(300);
      set_image(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
      test_random(250);
      set_image(4095, 1);
      test_random(150);
      set_image(3, 4095);
      test_random(150);
      set_image(12'($urandom_range(1, 64)), 12'($urandom_range(1, 64)));
      test_random(250);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
